FILE: rtl/lwd_pkg.sv
// shared types, constants and saturation helpers for the lagrange weight block
package lwd_pkg;

  localparam int MAX_POINTS = 16;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam logic signed [47:0] WMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] WMIN = 48'sh8000_0000_0000;
  localparam logic signed [47:0] QONE = 48'sh0000_0100_0000;

  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_DERIV_ORDER = 2'd1,
    REG_MATCH_TOL   = 2'd2
  } lwd_reg_t;

  // result of an arithmetic unit or of the saturating adder
  typedef struct packed {
    logic               done;
    logic               fault;
    logic signed [47:0] value;
  } lwd_res_t;

  typedef struct packed {
    logic               start;
    logic signed [47:0] a;
    logic signed [47:0] b;
  } lwd_mul_req_t;

  typedef struct packed {
    logic               start;
    logic               recip;
    logic signed [32:0] num;
    logic signed [32:0] den;
  } lwd_div_req_t;

  // signed result from a magnitude and a sign, clamped to 48 bits
  function automatic lwd_res_t sat_mag(input logic [71:0] mag, input logic neg,
                                       input logic force_ovf);
    lwd_res_t r;
    r.done  = 1'b0;
    r.fault = 1'b0;
    if (!neg) begin
      if (mag > 72'h7FFF_FFFF_FFFF) begin
        r.value = WMAX;
        r.fault = 1'b1;
      end else begin
        r.value = 48'(mag);
      end
    end else begin
      if (force_ovf || mag > 72'h8000_0000_0000) begin
        r.value = WMIN;
        r.fault = 1'b1;
      end else begin
        r.value = 48'(72'd0 - mag);
      end
    end
    return r;
  endfunction

  function automatic lwd_res_t add_sat(input logic signed [47:0] a,
                                       input logic signed [47:0] b,
                                       input logic sub);
    lwd_res_t r;
    logic signed [48:0] sum;
    sum = sub ? ({a[47], a} - {b[47], b}) : ({a[47], a} + {b[47], b});
    r.done = 1'b0;
    if (sum[48] != sum[47]) begin
      r.fault = 1'b1;
      r.value = sum[48] ? WMIN : WMAX;
    end else begin
      r.fault = 1'b0;
      r.value = sum[47:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/lwd_mul.sv
// bit-serial q24.24 multiplier with saturation
module lwd_mul import lwd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  lwd_mul_req_t req,
  output lwd_res_t     res
);

  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] ma;
  logic [47:0] acc_hi;
  logic [47:0] acc_lo;
  logic        neg;
  logic [48:0] sum;
  logic [95:0] prod;
  lwd_res_t    fin;

  assign sum  = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, ma} : 49'd0);
  assign prod = {acc_hi, acc_lo};

  always_comb begin
    fin      = sat_mag(prod[95:24], neg, prod == (96'd1 << 71));
    fin.done = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (!busy && req.start) begin
        ma     <= req.a[47] ? 48'(-req.a) : req.a;
        acc_lo <= req.b[47] ? 48'(-req.b) : req.b;
        acc_hi <= '0;
        neg    <= req.a[47] ^ req.b[47];
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (cnt == 6'd48) begin
          res  <= fin;
          busy <= 1'b0;
        end else begin
          acc_hi <= sum[48:1];
          acc_lo <= {sum[0], acc_lo[47:1]};
          cnt    <= cnt + 6'd1;
        end
      end
    end
  end

endmodule

FILE: rtl/lwd_div.sv
// bit-serial restoring divider for ratios and reciprocals
module lwd_div import lwd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  lwd_div_req_t req,
  output lwd_res_t     res
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] dmag;
  logic [32:0] nmag;
  logic [56:0] q;
  logic [33:0] rem;
  logic [33:0] rem_sh;
  logic [34:0] trial;
  logic        neg;
  lwd_res_t    fin;

  assign nmag   = req.num[32] ? 33'(-req.num) : req.num;
  assign rem_sh = {rem[32:0], q[56]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dmag};

  always_comb begin
    fin      = sat_mag(72'(q), neg, 1'b0);
    fin.done = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (!busy && req.start) begin
        if (req.den == '0) begin
          // zero divisor gives zero and flags it
          res.done  <= 1'b1;
          res.fault <= 1'b1;
          res.value <= '0;
        end else begin
          dmag <= req.den[32] ? 33'(-req.den) : req.den;
          q    <= req.recip ? (57'd1 << 40) : {nmag, 24'd0};
          neg  <= req.recip ? req.den[32] : (req.num[32] ^ req.den[32]);
          rem  <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == 6'd57) begin
          res  <= fin;
          busy <= 1'b0;
        end else begin
          if (!trial[34]) begin
            rem <= trial[33:0];
            q   <= {q[55:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[55:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

endmodule

FILE: rtl/lagrange_weights_with_derivatives.sv
// top level: node store, weight sequencer, output register and register port
//
// usage
// - input channel (in_valid / in_stall): a request with kind 0 writes value
//   into node slot node_index and returns nothing; a request with kind 1 is a
//   sample position and returns one weight per node in use, in node order,
//   last set on the final one
// - output channel (out_valid / out_stall): weight_index, weight (q24.24),
//   last, error; one output register, the sequencer holds if full and stalled
// - registers over apb: point_count at 0x0, derivative_order at 0x4,
//   match_tolerance at 0x8; write them only while the block is idle
// - a node load does not stall the input; a sample costs a division and
//   a product per node pair at order 0, and more per pair at orders 1 to
//   3, plus the final sums for each node; its run time is set by the
//   bit-serial divider and multiplier, one shared unit of each, used one
//   after the other
// - in_stall is high for the whole of a sample; the next request is taken
//   once the last weight sits in the output register
// - reset clears the sequencer, the output valid and the registers to
//   point_count 2, order 0, tolerance 0; node slots hold nothing until written
module lagrange_weights_with_derivatives import lwd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [3:0]         node_index,
  input  logic signed [31:0] value,
  // output requests
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         weight_index,
  output logic signed [47:0] weight,
  output logic               last,
  output logic               error,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [29:0] {
    ST_IDLE   = 30'h00000001,
    ST_MATCH  = 30'h00000002,
    ST_ROW    = 30'h00000004,
    ST_JCHK   = 30'h00000008,
    ST_JRAT   = 30'h00000010,
    ST_JPMUL  = 30'h00000020,
    ST_JREC   = 30'h00000040,
    ST_JR2    = 30'h00000080,
    ST_JR3    = 30'h00000100,
    ST_JD1    = 30'h00000200,
    ST_JD2    = 30'h00000400,
    ST_FSTART = 30'h00000800,
    ST_FSQ    = 30'h00001000,
    ST_FE2    = 30'h00002000,
    ST_FS1X2  = 30'h00004000,
    ST_FT1    = 30'h00008000,
    ST_FT2    = 30'h00010000,
    ST_FTR1   = 30'h00020000,
    ST_FTR2   = 30'h00040000,
    ST_FTR3   = 30'h00080000,
    ST_FTR4   = 30'h00100000,
    ST_FA1    = 30'h00200000,
    ST_FA2    = 30'h00400000,
    ST_FBR    = 30'h00800000,
    ST_FM1    = 30'h01000000,
    ST_FM2    = 30'h02000000,
    ST_FM3    = 30'h04000000,
    ST_FM4    = 30'h08000000,
    ST_FW     = 30'h10000000,
    ST_EMIT   = 30'h20000000
  } lwd_state_t;

  function automatic logic signed [32:0] sub33(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    return {x[31], x} - {y[31], y};
  endfunction

  // registers
  logic [4:0]  point_count;
  logic [1:0]  derivative_order;
  logic [15:0] match_tolerance;

  // node store, written by node loads only
  logic signed [31:0] store [MAX_POINTS];

  lwd_state_t         state;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   j;
  logic [CNT_W-1:0]   n;
  logic [1:0]         order;
  logic               mvalid;
  logic [PT_W-1:0]    m;
  logic signed [31:0] s;
  logic signed [31:0] xi;
  logic signed [31:0] xj;
  logic signed [31:0] xm;
  logic signed [47:0] p, s1, s2, s3, e, a, t, u, r, w;
  logic               fault;

  logic               in_accept;
  logic               cfg_write;
  logic [7:0]         pc8;
  logic [CNT_W-1:0]   n_val;
  logic [PT_W-1:0]    rd_idx;
  logic signed [31:0] x_rd;
  logic signed [32:0] dm;
  logic [32:0]        dm_mag;
  logic               skip_j;
  logic               branch;
  logic               emit_load;
  logic signed [32:0] sxm;

  logic signed [47:0] add_a, add_b;
  logic               add_sub;
  lwd_res_t           add_res;

  lwd_mul_req_t       mul_req;
  lwd_div_req_t       div_req;
  lwd_res_t           mul_res;
  lwd_res_t           div_res;

  lwd_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .res(mul_res));
  lwd_div u_div (.clk(clk), .rst(rst), .req(div_req), .res(div_res));

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // point count of 0 acts as 1, beyond the store as the store size
  assign pc8   = 8'(point_count);
  assign n_val = (pc8 == 8'd0) ? CNT_W'(1) :
                 (pc8 > 8'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pc8);

  assign rd_idx = (state == ST_ROW) ? i[PT_W-1:0] : j[PT_W-1:0];
  assign x_rd   = store[rd_idx];
  assign dm     = sub33(s, x_rd);
  assign dm_mag = dm[32] ? 33'(-dm) : dm;
  assign skip_j = (j == i) || (mvalid && (j == CNT_W'(m)));
  assign branch = mvalid && (i != CNT_W'(m));
  assign sxm    = sub33(s, xm);

  assign emit_load = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    case (paddr[3:2])
      REG_POINT_COUNT: prdata = 32'(point_count);
      REG_DERIV_ORDER: prdata = 32'(derivative_order);
      REG_MATCH_TOL:   prdata = 32'(match_tolerance);
      default:         prdata = '0;
    endcase
  end

  // one saturating adder shared by all sum steps
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      ST_JREC:  begin add_a = s1; add_b = div_res.value; end
      ST_JR2:   begin add_a = s2; add_b = mul_res.value; end
      ST_JD1:   begin add_a = u;  add_b = u;  end
      ST_JD2:   begin add_a = s3; add_b = u;  end
      ST_FE2:   begin add_a = t;  add_b = s2; add_sub = 1'b1; end
      ST_FS1X2: begin add_a = s1; add_b = s1; end
      ST_FTR1:  begin add_a = u;  add_b = u;  end
      ST_FTR2:  begin add_a = e;  add_b = u;  end
      ST_FTR3:  begin add_a = t;  add_b = e;  add_sub = 1'b1; end
      ST_FTR4:  begin add_a = e;  add_b = s3; end
      ST_FA1:   begin add_a = a;  add_b = a;  end
      ST_FA2:   begin add_a = u;  add_b = a;  end
      ST_FM2:   begin add_a = a;  add_b = u;  end
      default:  begin add_a = '0; add_b = '0; end
    endcase
    add_res = add_sat(add_a, add_b, add_sub);
  end

  // unit requests
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = p;
    mul_req.b     = e;
    div_req.start = 1'b0;
    div_req.recip = 1'b0;
    div_req.num   = sub33(s, x_rd);
    div_req.den   = sub33(xi, x_rd);
    case (state)
      ST_JCHK: begin
        if (j != n && !skip_j) begin
          div_req.start = 1'b1;
        end
      end
      ST_JRAT: begin
        mul_req.start = div_res.done;
        mul_req.a     = p;
        mul_req.b     = div_res.value;
      end
      ST_JPMUL: begin
        div_req.start = mul_res.done && (order != 2'd0);
        div_req.recip = 1'b1;
        div_req.num   = '0;
        div_req.den   = sub33(s, xj);
      end
      ST_JREC: begin
        mul_req.start = div_res.done && (order >= 2'd2);
        mul_req.a     = div_res.value;
        mul_req.b     = div_res.value;
      end
      ST_JR2: begin
        mul_req.start = mul_res.done && (order == 2'd3);
        mul_req.a     = mul_res.value;
        mul_req.b     = r;
      end
      ST_FSTART: begin
        mul_req.start = (order >= 2'd2);
        mul_req.a     = s1;
        mul_req.b     = s1;
      end
      ST_FE2: begin
        mul_req.start = (order == 2'd3);
        mul_req.a     = t;
        mul_req.b     = s1;
      end
      ST_FT1: begin
        mul_req.start = mul_res.done;
        mul_req.a     = s1;
        mul_req.b     = s2;
      end
      ST_FBR: begin
        mul_req.start = 1'b1;
        if (branch) begin
          mul_req.a = {{7{sxm[32]}}, sxm, 8'd0};
        end
        mul_req.b = e;
      end
      ST_FM2: begin
        div_req.start = 1'b1;
        div_req.recip = 1'b1;
        div_req.num   = '0;
        div_req.den   = sub33(xi, xm);
      end
      ST_FM3: begin
        mul_req.start = div_res.done;
        mul_req.a     = a;
        mul_req.b     = div_res.value;
      end
      ST_FM4: begin
        mul_req.start = mul_res.done;
        mul_req.a     = p;
        mul_req.b     = mul_res.value;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  // node store
  always_ff @(posedge clk) begin
    if (in_accept && !kind && (32'(node_index) < MAX_POINTS)) begin
      store[PT_W'(node_index)] <= value;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count      <= 5'd2;
      derivative_order <= 2'd0;
      match_tolerance  <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_POINT_COUNT: point_count      <= pwdata[4:0];
        REG_DERIV_ORDER: derivative_order <= pwdata[1:0];
        REG_MATCH_TOL:   match_tolerance  <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && kind) begin
            s      <= value;
            n      <= n_val;
            order  <= derivative_order;
            mvalid <= 1'b0;
            i      <= '0;
            j      <= '0;
            // the node-match search only matters for derivatives
            state  <= (derivative_order != 2'd0) ? ST_MATCH : ST_ROW;
          end
        end
        ST_MATCH: begin
          if (dm_mag <= {17'd0, match_tolerance}) begin
            mvalid <= 1'b1;
            m      <= j[PT_W-1:0];
            xm     <= x_rd;
            state  <= ST_ROW;
          end else if (j == n - CNT_W'(1)) begin
            state <= ST_ROW;
          end else begin
            j <= j + CNT_W'(1);
          end
        end
        ST_ROW: begin
          xi    <= x_rd;
          p     <= QONE;
          s1    <= '0;
          s2    <= '0;
          s3    <= '0;
          fault <= 1'b0;
          j     <= '0;
          state <= ST_JCHK;
        end
        ST_JCHK: begin
          if (j == n) begin
            state <= ST_FSTART;
          end else if (skip_j) begin
            j <= j + CNT_W'(1);
          end else begin
            xj    <= x_rd;
            state <= ST_JRAT;
          end
        end
        ST_JRAT: begin
          if (div_res.done) begin
            fault <= fault | div_res.fault;
            state <= ST_JPMUL;
          end
        end
        ST_JPMUL: begin
          if (mul_res.done) begin
            p     <= mul_res.value;
            fault <= fault | mul_res.fault;
            if (order == 2'd0) begin
              j     <= j + CNT_W'(1);
              state <= ST_JCHK;
            end else begin
              state <= ST_JREC;
            end
          end
        end
        ST_JREC: begin
          if (div_res.done) begin
            r     <= div_res.value;
            s1    <= add_res.value;
            fault <= fault | div_res.fault | add_res.fault;
            if (order >= 2'd2) begin
              state <= ST_JR2;
            end else begin
              j     <= j + CNT_W'(1);
              state <= ST_JCHK;
            end
          end
        end
        ST_JR2: begin
          if (mul_res.done) begin
            s2    <= add_res.value;
            fault <= fault | mul_res.fault | add_res.fault;
            if (order == 2'd3) begin
              state <= ST_JR3;
            end else begin
              j     <= j + CNT_W'(1);
              state <= ST_JCHK;
            end
          end
        end
        ST_JR3: begin
          if (mul_res.done) begin
            u     <= mul_res.value;
            fault <= fault | mul_res.fault;
            state <= ST_JD1;
          end
        end
        ST_JD1: begin
          u     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= ST_JD2;
        end
        ST_JD2: begin
          s3    <= add_res.value;
          fault <= fault | add_res.fault;
          j     <= j + CNT_W'(1);
          state <= ST_JCHK;
        end
        ST_FSTART: begin
          case (order)
            2'd0: begin
              w     <= p;
              state <= ST_EMIT;
            end
            2'd1: begin
              e     <= s1;
              a     <= QONE;
              state <= ST_FBR;
            end
            default: begin
              state <= ST_FSQ;
            end
          endcase
        end
        ST_FSQ: begin
          if (mul_res.done) begin
            t     <= mul_res.value;
            fault <= fault | mul_res.fault;
            state <= ST_FE2;
          end
        end
        ST_FE2: begin
          fault <= fault | add_res.fault;
          if (order == 2'd2) begin
            e     <= add_res.value;
            state <= ST_FS1X2;
          end else begin
            a     <= add_res.value;
            state <= ST_FT1;
          end
        end
        ST_FS1X2: begin
          a     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= ST_FBR;
        end
        ST_FT1: begin
          if (mul_res.done) begin
            t     <= mul_res.value;
            fault <= fault | mul_res.fault;
            state <= ST_FT2;
          end
        end
        ST_FT2: begin
          if (mul_res.done) begin
            u     <= mul_res.value;
            fault <= fault | mul_res.fault;
            state <= ST_FTR1;
          end
        end
        ST_FTR1: begin
          e     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= ST_FTR2;
        end
        ST_FTR2: begin
          e     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= ST_FTR3;
        end
        ST_FTR3: begin
          e     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= ST_FTR4;
        end
        ST_FTR4: begin
          e     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= branch ? ST_FA1 : ST_FBR;
        end
        ST_FA1: begin
          u     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= ST_FA2;
        end
        ST_FA2: begin
          a     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= ST_FBR;
        end
        ST_FBR: begin
          state <= branch ? ST_FM1 : ST_FW;
        end
        ST_FM1: begin
          if (mul_res.done) begin
            u     <= mul_res.value;
            fault <= fault | mul_res.fault;
            state <= ST_FM2;
          end
        end
        ST_FM2: begin
          a     <= add_res.value;
          fault <= fault | add_res.fault;
          state <= ST_FM3;
        end
        ST_FM3: begin
          if (div_res.done) begin
            fault <= fault | div_res.fault;
            state <= ST_FM4;
          end
        end
        ST_FM4: begin
          if (mul_res.done) begin
            fault <= fault | mul_res.fault;
            state <= ST_FW;
          end
        end
        ST_FW: begin
          if (mul_res.done) begin
            w     <= mul_res.value;
            fault <= fault | mul_res.fault;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid    <= 1'b1;
            weight_index <= 4'(i);
            weight       <= w;
            last         <= (i == n - CNT_W'(1));
            error        <= fault;
            i            <= i + CNT_W'(1);
            state        <= (i == n - CNT_W'(1)) ? ST_IDLE : ST_ROW;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_match_in_range: assert property (@(posedge clk) disable iff (rst)
    mvalid |-> (CNT_W'(m) < n))
    else $error("matched node outside the nodes in use");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_load && (i == n - CNT_W'(1))) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after the last weight");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_req.start && div_req.start))
    else $error("multiplier and divider started together");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("output loaded outside the emit step");
`endif

endmodule

FILE: tb/tb_lagrange_weights_with_derivatives.sv
// testbench for the lagrange weight block: scoreboard class, request drivers and checks
module tb_lagrange_weights_with_derivatives;
  import lwd_pkg::*;

  // one expected weight
  typedef struct {
    logic [3:0]  idx;
    logic [47:0] w;
    logic        last;
    logic        err;
  } weight_t;

  // prediction of the weights and checking of what comes out
  class lwd_scoreboard;
    longint      nodes[MAX_POINTS];
    int unsigned npts;
    int unsigned order;
    int unsigned tol;
    bit          fault;
    weight_t     pending[$];
    int          mismatches;
    int          failures;

    function new();
      foreach (nodes[k]) nodes[k] = 0;
      npts = 2;
      order = 0;
      tol = 0;
      mismatches = 0;
      failures = 0;
    endfunction

    function void set_reg(lwd_reg_t r, logic [31:0] v);
      case (r)
        REG_POINT_COUNT: npts = v & 31;
        REG_DERIV_ORDER: order = v & 3;
        REG_MATCH_TOL:   tol = v & 16'hFFFF;
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function longint clampw(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) begin
        fault = 1;
        return 64'sh7FFF_FFFF_FFFF;
      end
      if (v < -64'sh8000_0000_0000) begin
        fault = 1;
        return -64'sh8000_0000_0000;
      end
      return v;
    endfunction

    function longint addw(longint a, longint b);
      return clampw(a + b);
    endfunction

    function longint subw(longint a, longint b);
      return clampw(a - b);
    endfunction

    function longint triple(longint a);
      return addw(addw(a, a), a);
    endfunction

    function longint from_mag(longint unsigned m, bit neg);
      if (!neg) begin
        if (m > 64'h7FFF_FFFF_FFFF) begin
          fault = 1;
          return 64'sh7FFF_FFFF_FFFF;
        end
        return longint'(m);
      end
      if (m > 64'h8000_0000_0000) begin
        fault = 1;
        return -64'sh8000_0000_0000;
      end
      return -longint'(m);
    endfunction

    // q24.24 product, truncated toward zero in magnitude
    function longint mulw(longint a, longint b);
      longint unsigned ma, mb, ah, al, bh, bl, hh, m;
      bit neg;
      ma = mag(a);
      mb = mag(b);
      ah = ma >> 24;
      al = ma & 64'hFF_FFFF;
      bh = mb >> 24;
      bl = mb & 64'hFF_FFFF;
      hh = ah * bh;
      neg = (a < 0) != (b < 0);
      if (hh >= (64'd1 << 23)) return from_mag(64'd1 << 48, neg);
      m = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
      return from_mag(m, neg);
    endfunction

    function longint ratio(longint num, longint den);
      if (den == 0) begin
        fault = 1;
        return 0;
      end
      return from_mag((mag(num) << 24) / mag(den), (num < 0) != (den < 0));
    endfunction

    function longint recip(longint d);
      if (d == 0) begin
        fault = 1;
        return 0;
      end
      return from_mag((64'd1 << 40) / mag(d), d < 0);
    endfunction

    // weights of all nodes in use at sample position s
    function void weigh_sample(longint s);
      int n, m;
      longint xi, p, s1, s2, s3, e, a, w, r, r2, r3, sq, e2, inner;
      weight_t x;
      n = npts;
      m = -1;
      if (n < 1) n = 1;
      if (n > MAX_POINTS) n = MAX_POINTS;
      if (order != 0) begin
        for (int i = 0; i < n; i++) begin
          if (mag(s - nodes[i]) <= tol) begin
            m = i;
            break;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        xi = nodes[i];
        p = 64'sd1 << 24;
        s1 = 0; s2 = 0; s3 = 0; e = 0; a = 0;
        fault = 0;
        for (int j = 0; j < n; j++) begin
          if (j == i || j == m) continue;
          p = mulw(p, ratio(s - nodes[j], xi - nodes[j]));
          if (order == 0) continue;
          r = recip(s - nodes[j]);
          s1 = addw(s1, r);
          if (order >= 2) begin
            r2 = mulw(r, r);
            s2 = addw(s2, r2);
            if (order == 3) begin
              r3 = mulw(r2, r);
              s3 = addw(s3, addw(r3, r3));
            end
          end
        end
        if (order == 1) begin
          e = s1;
          a = 64'sd1 << 24;
        end else if (order == 2) begin
          e = subw(mulw(s1, s1), s2);
          a = addw(s1, s1);
        end else if (order == 3) begin
          sq = mulw(s1, s1);
          e2 = subw(sq, s2);
          e = addw(subw(mulw(sq, s1), triple(mulw(s1, s2))), s3);
          if (m >= 0 && i != m) a = triple(e2);
        end
        if (order == 0) begin
          w = p;
        end else if (m < 0 || i == m) begin
          w = mulw(p, e);
        end else begin
          inner = addw(a, mulw((s - nodes[m]) * 256, e));
          w = mulw(p, mulw(inner, recip(xi - nodes[m])));
        end
        x.idx = i[3:0];
        x.w = w[47:0];
        x.last = (i == n - 1);
        x.err = fault;
        pending.push_back(x);
      end
    endfunction

    // an accepted input request
    function void note_request(logic k, logic [3:0] idx, logic signed [31:0] v);
      if (k == 1'b0) nodes[idx] = longint'(v);
      else weigh_sample(longint'(v));
    endfunction

    // an accepted output request against the oldest expected weight
    function void check_weight(logic [3:0] idx, logic [47:0] w, logic l, logic err);
      weight_t x;
      if (pending.size() == 0) begin
        failures++;
        if (mismatches++ < 10)
          $display("unexpected weight: index %0d weight %h", idx, w);
        return;
      end
      x = pending.pop_front();
      if (idx !== x.idx || w !== x.w || l !== x.last || err !== x.err) begin
        failures++;
        if (mismatches++ < 10)
          $display("weight mismatch: exp idx %0d w %h last %0d err %0d, got idx %0d w %h last %0d err %0d",
                   x.idx, x.w, x.last, x.err, idx, w, l, err);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic [3:0]         node_index;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         weight_index;
  logic signed [47:0] weight;
  logic               last;
  logic               error;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  lwd_scoreboard sb;
  int            send_idle_pct;  // chance per cycle that the sender idles
  int            stall_pct;      // chance per cycle that the receiver stalls
  int            hold_left;      // cycles of forced receiver hold-off still to go

  lagrange_weights_with_derivatives dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .node_index(node_index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .weight_index(weight_index), .weight(weight), .last(last), .error(error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random stalls, or a long forced hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // every weight handed over is checked at the edge that takes it
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_weight(weight_index, weight, last, error);
  end

  // hard stop in case the block hangs
  initial begin
    #400_000_000;
    $display("tb_lagrange_weights_with_derivatives: FAIL");
    $finish;
  end

  // one input request; valid stays high after acceptance until the next negedge
  task automatic send_request(logic k, logic [3:0] idx, logic signed [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    node_index = idx;
    value = v;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, idx, v);
  endtask

  // sender pauses until every expected weight is out and the block is quiet
  task automatic drain_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle (pready is always high)
  task automatic reg_write(lwd_reg_t r, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.set_reg(r, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(int unsigned n, int unsigned ord, int unsigned t);
    drain_block();
    reg_write(REG_POINT_COUNT, n);
    reg_write(REG_DERIV_ORDER, ord);
    reg_write(REG_MATCH_TOL, t);
  endtask

  // positions: mostly a few units around zero, sometimes anywhere
  function automatic logic signed [31:0] pick_pos();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
  endfunction

  // sample near a node in use so that the match branch is reached often
  function automatic logic signed [31:0] near_node();
    longint base, off;
    int unsigned lim;
    lim = (sb.npts == 0) ? 0 : ((sb.npts > 16) ? 15 : sb.npts - 1);
    base = sb.nodes[$urandom_range(lim)];
    off = longint'($urandom_range(0, 2 * sb.tol + 4)) - sb.tol - 2;
    return 32'(base + off);
  endfunction

  // one random phase of roughly count requests under the current idling mode
  task automatic random_phase(int count);
    int done;
    int burst;
    done = 0;
    while (done < count) begin
      configure(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                $urandom_range(3),
                ($urandom_range(3) == 0) ? 0 :
                ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535));
      burst = $urandom_range(6, 14);
      repeat (burst) begin
        if ($urandom_range(99) < 55)
          send_request(1'b0, $urandom, pick_pos());
        else if ($urandom_range(99) < 70)
          send_request(1'b1, $urandom, near_node());
        else
          send_request(1'b1, $urandom, pick_pos());
        done++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    kind = 1'b0;
    node_index = '0;
    value = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: fill every slot, extremes of position and a repeated node
    send_request(1'b0, 4'd0, 32'sd0);
    send_request(1'b0, 4'd1, 32'sh0001_0000);
    send_request(1'b0, 4'd2, 32'sh8000_0000);
    send_request(1'b0, 4'd3, 32'sh7FFF_FFFF);
    send_request(1'b0, 4'd4, 32'sh0001_0000);
    for (int k = 5; k < MAX_POINTS; k++)
      send_request(1'b0, k[3:0], (k - 10) * 32'sh0003_0000 + 32'sh0000_4000);

    // reset settings: two nodes, plain weights
    send_request(1'b1, 4'd0, 32'sh0000_8000);
    // exact hit on a node, first derivative
    configure(3, 1, 0);
    send_request(1'b1, 4'd0, 32'sd0);
    // within the widest tolerance of node 1, second derivative
    configure(3, 2, 65535);
    send_request(1'b1, 4'd0, 32'sh0001_0064);
    // equal nodes 1 and 4 give a zero divisor, third derivative
    configure(5, 3, 0);
    send_request(1'b1, 4'd0, 32'sh0003_0000);
    // extreme samples against extreme nodes, saturation
    configure(4, 0, 0);
    send_request(1'b1, 4'd0, 32'sh8000_0000);
    send_request(1'b1, 4'd0, 32'sh7FFF_FFFF);
    // point count zero acts as one node
    configure(0, 3, 65535);
    send_request(1'b1, 4'd0, $urandom);
    // point count above the store acts as all sixteen nodes
    configure(31, 0, 0);
    send_request(1'b1, 4'd0, 32'sh0000_2000);

    // random phases: no idling, sender idle, receiver stalling, both
    send_idle_pct = 0;  stall_pct = 0;
    random_phase(100);
    send_idle_pct = 51; stall_pct = 0;
    random_phase(100);
    send_idle_pct = 0;  stall_pct = 51;
    random_phase(90);

    // long receiver hold-off while samples keep coming, so the input stalls
    configure(2, 0, 0);
    @(negedge clk);
    hold_left = 3000;
    repeat (4) send_request(1'b1, 4'd0, pick_pos());
    random_phase(12);

    send_idle_pct = 38; stall_pct = 38;
    random_phase(100);

    drain_block();
    repeat (50) @(posedge clk);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("tb_lagrange_weights_with_derivatives: PASS");
    end else begin
      $display("tb_lagrange_weights_with_derivatives: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lwd_pkg.sv
rtl/lwd_mul.sv
rtl/lwd_div.sv
rtl/lagrange_weights_with_derivatives.sv
tb/tb_lagrange_weights_with_derivatives.sv
